>>> hw/rtl/cfr_pkg.sv
package cfr_pkg;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned COUNT_W   = 17;
  localparam int unsigned LIMIT_W   = 16;
  localparam int unsigned TICK_W    = 16;
  localparam int unsigned TOTAL_W   = 32;
  localparam int unsigned RULE_W    = 39;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RULE_FIRST   = 3'd2;

  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  typedef enum logic [2:0] {
    V_ALLOW      = 3'd0,
    V_RANGE      = 3'd1,
    V_BAN        = 3'd2,
    V_RATE       = 3'd3,
    V_UNTRACKED  = 3'd4,
    V_TICK       = 3'd5,
    V_TICK_RESET = 3'd6
  } verdict_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_UPDATE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              en;
    logic [5:0]        len;
    logic [ADDR_W-1:0] net;
  } rule_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] count;
  } entry_t;

endpackage

>>> hw/rtl/cfr_ram.sv
module cfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/cfr_rule_match.sv
module cfr_rule_match
  import cfr_pkg::*;
#(
  parameter int unsigned RANGE_RULES = 4
) (
  input  rule_t [RANGE_RULES-1:0] rules,
  input  logic [ADDR_W-1:0]       addr,
  output logic                    hit
);

  logic [RANGE_RULES-1:0] rule_hit;

  always_comb begin
    logic [ADDR_W-1:0] mask;
    for (int r = 0; r < RANGE_RULES; r++) begin
      // prefix length 0 matches everything, over 32 never matches
      mask = (rules[r].len == 6'd0) ? '0 : ('1 << (6'd32 - rules[r].len));
      rule_hit[r] = rules[r].en && (rules[r].len <= 6'd32) &&
                    ((addr & mask) == (rules[r].net & mask));
    end
  end

  assign hit = |rule_hit;

endmodule

>>> hw/rtl/cidr_filter_rate_limiter_core.sv
// Source-address filter with CIDR block rules and a fixed-window rate limiter.
// Input channel (in_valid/in_ready): in_operation selects a request (src/dst
// address) or a tick. Every transaction yields exactly one result on the output
// channel (out_valid/out_ready) with the verdict, the addresses (zero for a
// tick) and the running count of dropped requests.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 rate limit,
// 1 window length, 2.. range rules); the user must write only while no
// transaction is in flight, which the block does not enforce.
// A tick or a range-rule drop goes from ST_CHECK straight to ST_DONE; any
// other request walks the tracking table in the entry RAM one entry per cycle
// in ST_SCAN until the source is found or the table ends, then passes
// ST_UPDATE and ST_DONE. One transaction is in work at a time, and the next
// is accepted the cycle after the result is loaded.
// The result sits in an output register, so a new transaction is accepted while
// the receiver stalls; the block then holds its finished result until the
// output register frees up. Reset clears all entry valid and ban flags, the
// tick and drop counters and the registers to their defaults; no RAM clear pass
// is needed because entry data is only used when its valid flag is set.
module cidr_filter_rate_limiter_core
  import cfr_pkg::*;
#(
  parameter int unsigned TRACK_ENTRIES = 16,
  parameter int unsigned RANGE_RULES   = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_operation,
  input  logic [ADDR_W-1:0]    in_src_ip,
  input  logic [ADDR_W-1:0]    in_dst_ip,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_verdict,
  output logic [ADDR_W-1:0]    out_src_ip,
  output logic [ADDR_W-1:0]    out_dst_ip,
  output logic [TOTAL_W-1:0]   out_blocked_total,

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RULE_W-1:0]    cfg_wdata
);

  localparam int unsigned IW = (TRACK_ENTRIES > 1) ? $clog2(TRACK_ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TRACK_ENTRIES - 1);

  // configuration registers
  logic [LIMIT_W-1:0]       rate_limit_r;
  logic [TICK_W-1:0]        window_ticks_r;
  rule_t [RANGE_RULES-1:0]  rules_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_limit_r   <= LIMIT_W'(10);
      window_ticks_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_RATE_LIMIT) begin
        rate_limit_r <= cfg_wdata[LIMIT_W-1:0];
      end
      if (cfg_index == CFG_WINDOW_TICKS) begin
        window_ticks_r <= cfg_wdata[TICK_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rules_r <= '0;
    end else if (cfg_we) begin
      for (int r = 0; r < RANGE_RULES; r++) begin
        if (cfg_index == CFG_IDX_W'(CFG_RULE_FIRST + r)) begin
          rules_r[r] <= cfg_wdata;
        end
      end
    end
  end

  // control and datapath state
  state_t                state_r, state_nxt;
  logic                  op_r;
  logic [ADDR_W-1:0]     src_r, dst_r;
  logic [IW-1:0]         rd_idx_r;
  logic                  hit_found_r, free_found_r;
  logic [IW-1:0]         hit_idx_r, free_idx_r;
  logic [COUNT_W-1:0]    hit_cnt_r;
  verdict_t              verdict_r;
  logic [TRACK_ENTRIES-1:0] valid_r, banned_r;
  logic [TICK_W-1:0]     tick_count_r;
  logic [TOTAL_W-1:0]    drop_total_r, drop_total_nxt;
  logic                  out_valid_r;
  verdict_t              out_verdict_r;
  logic [ADDR_W-1:0]     out_src_r, out_dst_r;
  logic [TOTAL_W-1:0]    out_blocked_r;

  logic                  range_hit;
  logic                  ram_we, ram_re;
  logic [IW-1:0]         ram_raddr;
  entry_t                ram_wdata, ram_rdata;
  logic                  scan_hit, scan_last;
  logic                  out_free, out_load;

  cfr_rule_match #(
    .RANGE_RULES(RANGE_RULES)
  ) u_rule_match (
    .rules(rules_r),
    .addr (src_r),
    .hit  (range_hit)
  );

  cfr_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TRACK_ENTRIES)
  ) u_entry_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(hit_found_r ? hit_idx_r : free_idx_r),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign scan_hit  = valid_r[rd_idx_r] && (ram_rdata.addr == src_r);
  assign scan_last = (rd_idx_r == LAST_IDX);
  assign out_free  = !out_valid_r || out_ready;

  // tick handling
  logic [TICK_W-1:0] tick_inc;
  logic              window_end;
  assign tick_inc   = tick_count_r + TICK_W'(1);
  assign window_end = (window_ticks_r != '0) && (tick_inc >= window_ticks_r);

  // count update for the entry selected by the scan
  logic [COUNT_W-1:0] base_cnt, cnt_nxt;
  logic               tracked, is_banned, over_limit;
  assign base_cnt   = hit_found_r ? hit_cnt_r : '0;
  assign cnt_nxt    = (base_cnt == COUNT_MAX) ? base_cnt : base_cnt + COUNT_W'(1);
  assign tracked    = hit_found_r || free_found_r;
  assign is_banned  = hit_found_r && banned_r[hit_idx_r];
  assign over_limit = cnt_nxt > {1'b0, rate_limit_r};
  assign ram_wdata  = '{addr: src_r, count: cnt_nxt};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (op_r == OP_TICK || range_hit) state_nxt = ST_DONE;
        else                              state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_hit || scan_last) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready  = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    ram_we    = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_ready = rst_n;
      ST_CHECK: ram_re = (op_r == OP_REQUEST) && !range_hit;
      ST_SCAN: begin
        ram_re    = !scan_hit && !scan_last;
        ram_raddr = rd_idx_r + IW'(1);
      end
      ST_UPDATE: ram_we = tracked && !is_banned;
      ST_DONE:   out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      op_r  <= in_operation;
      src_r <= in_src_ip;
      dst_r <= in_dst_ip;
    end
    if (state_r == ST_CHECK) begin
      rd_idx_r     <= '0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      if (op_r == OP_TICK) begin
        verdict_r <= window_end ? V_TICK_RESET : V_TICK;
      end else begin
        verdict_r <= V_RANGE;
      end
    end
    if (state_r == ST_SCAN) begin
      if (scan_hit) begin
        hit_found_r <= 1'b1;
        hit_idx_r   <= rd_idx_r;
        hit_cnt_r   <= ram_rdata.count;
      end else if (!valid_r[rd_idx_r] && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= rd_idx_r;
      end
      rd_idx_r <= rd_idx_r + IW'(1);
    end
    if (state_r == ST_UPDATE) begin
      if (is_banned)       verdict_r <= V_BAN;
      else if (!tracked)   verdict_r <= V_UNTRACKED;
      else if (over_limit) verdict_r <= V_RATE;
      else                 verdict_r <= V_ALLOW;
    end
  end

  // table flags and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      banned_r     <= '0;
      tick_count_r <= '0;
    end else begin
      if (state_r == ST_CHECK && op_r == OP_TICK) begin
        if (window_end) begin
          tick_count_r <= '0;
          // free every entry that is not banned
          valid_r      <= valid_r & banned_r;
        end else begin
          tick_count_r <= tick_inc;
        end
      end
      if (ram_we) begin
        valid_r[hit_found_r ? hit_idx_r : free_idx_r]  <= 1'b1;
        banned_r[hit_found_r ? hit_idx_r : free_idx_r] <= over_limit;
      end
    end
  end

  assign drop_total_nxt = (verdict_r == V_RANGE || verdict_r == V_BAN ||
                           verdict_r == V_RATE) ? drop_total_r + TOTAL_W'(1)
                                                : drop_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_total_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_load) begin
        drop_total_r <= drop_total_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_verdict_r <= verdict_r;
      out_src_r     <= (op_r == OP_TICK) ? '0 : src_r;
      out_dst_r     <= (op_r == OP_TICK) ? '0 : dst_r;
      out_blocked_r <= drop_total_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_verdict       = out_verdict_r;
  assign out_src_ip        = out_src_r;
  assign out_dst_ip        = out_dst_r;
  assign out_blocked_total = out_blocked_r;

  // a banned entry is never freed by a window end
  a_banned_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (banned_r & ~valid_r) == '0)
    else $error("banned flag set on an invalid entry");

  // a tick never touches the entry table
  a_tick_skips_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK && op_r == OP_TICK) |=> state_r == ST_DONE)
    else $error("tick entered the table scan");

  // untracked only when every entry is in use
  a_untracked_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE && !hit_found_r && !free_found_r) |-> &valid_r)
    else $error("request left untracked while a free entry exists");

  // drop total moves only when a result is loaded
  a_drop_total_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_load |=> $stable(drop_total_r))
    else $error("drop total changed without a result");

endmodule

>>> tb/sv/cidr_filter_rate_limiter_core_tb.sv
`timescale 1ns / 100ps

module cidr_filter_rate_limiter_core_tb;
  import cfr_pkg::*;

  localparam int TRACK_N          = 16;
  localparam int RULES_N          = 4;
  localparam int POOL_N           = 24;
  localparam int PHASE_ITEMS      = 165;
  localparam int HOLD_CYCLES      = 300;
  localparam int STALL_LIMIT      = 2000;
  localparam int SETTLE_CYCLES    = TRACK_N + 4;
  localparam int FIRST_UNUSED_IDX = CFG_RULE_FIRST + RULES_N;

  typedef struct packed {
    verdict_t           verdict;
    logic [ADDR_W-1:0]  src;
    logic [ADDR_W-1:0]  dst;
    logic [TOTAL_W-1:0] total;
  } verdict_item_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_operation;
  logic [ADDR_W-1:0]    in_src_ip;
  logic [ADDR_W-1:0]    in_dst_ip;
  logic                 out_valid;
  logic                 out_ready;
  logic [2:0]           out_verdict;
  logic [ADDR_W-1:0]    out_src_ip;
  logic [ADDR_W-1:0]    out_dst_ip;
  logic [TOTAL_W-1:0]   out_blocked_total;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RULE_W-1:0]    cfg_wdata;

  // shadow copy of the filter state
  logic [LIMIT_W-1:0] rate_limit_q;
  logic [TICK_W-1:0]  window_len_q;
  rule_t              block_rules [RULES_N];
  logic [ADDR_W-1:0]  track_addr [TRACK_N];
  logic [COUNT_W-1:0] track_count [TRACK_N];
  bit                 track_banned [TRACK_N];
  bit                 track_valid [TRACK_N];
  logic [TICK_W-1:0]  ticks_seen;
  logic [TOTAL_W-1:0] drops_seen;

  verdict_item_t     pending_verdicts [$];
  logic [ADDR_W-1:0] src_pool [POOL_N];
  int                mismatches = 0;
  int                tx_idle_pct = 26;
  int                rx_idle_pct = 56;
  bit                hold_output = 1'b0;

  cidr_filter_rate_limiter_core #(
    .TRACK_ENTRIES(TRACK_N),
    .RANGE_RULES  (RULES_N)
  ) uut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit source_blocked(input logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] mask;
    int k;
    for (k = 0; k < RULES_N; k++) begin
      if (block_rules[k].en && block_rules[k].len <= ADDR_W) begin
        mask = (block_rules[k].len == 0) ? '0 :
               {ADDR_W{1'b1}} << (ADDR_W - block_rules[k].len);
        if ((addr & mask) == (block_rules[k].net & mask)) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic verdict_item_t filter_step(input logic op,
                                                input logic [ADDR_W-1:0] src,
                                                input logic [ADDR_W-1:0] dst);
    verdict_item_t res;
    int k, hit, free_slot;
    hit = -1;
    free_slot = -1;
    res.src = src;
    res.dst = dst;
    if (op == OP_TICK) begin
      ticks_seen = ticks_seen + 1'b1;
      res.verdict = V_TICK;
      res.src = '0;
      res.dst = '0;
      if (window_len_q != 0 && ticks_seen >= window_len_q) begin
        ticks_seen = '0;
        for (k = 0; k < TRACK_N; k++)
          if (!track_banned[k]) track_valid[k] = 1'b0;
        res.verdict = V_TICK_RESET;
      end
    end else if (source_blocked(src)) begin
      res.verdict = V_RANGE;
    end else begin
      for (k = 0; k < TRACK_N; k++) begin
        if (track_valid[k]) begin
          if (hit < 0 && track_addr[k] == src) hit = k;
        end else if (free_slot < 0) begin
          free_slot = k;
        end
      end
      if (hit >= 0 && track_banned[hit]) begin
        res.verdict = V_BAN;
      end else begin
        // unknown source takes the lowest free entry
        if (hit < 0 && free_slot >= 0) begin
          hit = free_slot;
          track_valid[hit] = 1'b1;
          track_banned[hit] = 1'b0;
          track_addr[hit] = src;
          track_count[hit] = '0;
        end
        if (hit < 0) begin
          res.verdict = V_UNTRACKED;
        end else begin
          if (track_count[hit] != COUNT_MAX) track_count[hit] = track_count[hit] + 1'b1;
          if (track_count[hit] > rate_limit_q) begin
            track_banned[hit] = 1'b1;
            res.verdict = V_RATE;
          end else begin
            res.verdict = V_ALLOW;
          end
        end
      end
    end
    if (res.verdict == V_RANGE || res.verdict == V_BAN || res.verdict == V_RATE)
      drops_seen = drops_seen + 1'b1;
    res.total = drops_seen;
    return res;
  endfunction

  task automatic offer_item(input logic op, input logic [ADDR_W-1:0] src,
                            input logic [ADDR_W-1:0] dst);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_src_ip    <= src;
    in_dst_ip    <= dst;
    do @(posedge clk); while (!in_ready);
    pending_verdicts.insert(pending_verdicts.size(), filter_step(op, src, dst));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RULE_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (idx == CFG_RATE_LIMIT) rate_limit_q = data[LIMIT_W-1:0];
    else if (idx == CFG_WINDOW_TICKS) window_len_q = data[TICK_W-1:0];
    else if (idx >= CFG_RULE_FIRST && idx < FIRST_UNUSED_IDX)
      block_rules[idx - CFG_RULE_FIRST] = data;
  endtask

  // only while nothing is in flight
  task automatic load_settings(input logic [LIMIT_W-1:0] limit,
                               input logic [TICK_W-1:0] window,
                               input logic [RULES_N-1:0][RULE_W-1:0] rules);
    logic [RULE_W-1:0] junk;
    int k;
    junk = RULE_W'({$urandom, $urandom});
    write_reg(CFG_RATE_LIMIT, {junk[RULE_W-1:LIMIT_W], limit});
    junk = RULE_W'({$urandom, $urandom});
    write_reg(CFG_WINDOW_TICKS, {junk[RULE_W-1:TICK_W], window});
    for (k = 0; k < RULES_N; k++)
      write_reg(CFG_IDX_W'(CFG_RULE_FIRST + k), rules[k]);
    // index with no register behind it
    write_reg(CFG_IDX_W'(FIRST_UNUSED_IDX + $urandom_range(1)), junk);
    cfg_we <= 1'b0;
  endtask

  task automatic report_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
    mismatches++;
    $display("%0t: %s expected %h got %h", $time, what, want, got);
  endtask

  always @(posedge clk) begin : check_results
    verdict_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, verdict %0d src %h",
                 $time, out_verdict, out_src_ip);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_verdict !== want.verdict)
          report_field("verdict", 32'(want.verdict), 32'(out_verdict));
        if (out_src_ip !== want.src) report_field("src_ip", want.src, out_src_ip);
        if (out_dst_ip !== want.dst) report_field("dst_ip", want.dst, out_dst_ip);
        if (out_blocked_total !== want.total)
          report_field("blocked_total", want.total, out_blocked_total);
      end
    end
  end

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_output) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("[cidr_filter_rate_limiter_core] ERROR");
    $finish;
  end

  task automatic test_reset_defaults();
    offer_item(OP_REQUEST, 32'h0A000001, 32'hFFFFFFFF);
    offer_item(OP_TICK, 32'hFFFFFFFF, 32'hFFFFFFFF);
    drain_results();
  endtask

  task automatic test_range_and_ban();
    // /32 all ones, prefix over 32, /24 with host bits, /8
    load_settings(16'd2, 16'd3, {{1'b1, 6'd32, 32'hFFFFFFFF},
                                 {1'b1, 6'd40, 32'h00000000},
                                 {1'b1, 6'd24, 32'hC0A8014D},
                                 {1'b1, 6'd8,  32'h0A000000}});
    offer_item(OP_REQUEST, 32'h0A010203, 32'h00000000);
    offer_item(OP_REQUEST, 32'hC0A801C8, 32'hFFFFFFFF);
    offer_item(OP_REQUEST, 32'hFFFFFFFF, 32'h00000000);
    repeat (4) offer_item(OP_REQUEST, 32'h00000000, 32'hFFFFFFFF);
    offer_item(OP_REQUEST, 32'hC0A80200, $urandom);
    repeat (3) offer_item(OP_TICK, 32'h0, 32'h0);
    offer_item(OP_REQUEST, 32'h00000000, $urandom);
    drain_results();
  endtask

  task automatic test_match_all_prefix();
    load_settings(16'd10, 16'd0, {39'd0, 39'd0, 39'd0, {1'b1, 6'd0, 32'h12345678}});
    offer_item(OP_REQUEST, $urandom, $urandom);
    drain_results();
  endtask

  task automatic test_disabled_rule_zero_limit();
    load_settings(16'd0, 16'd0, {39'd0, 39'd0, 39'd0, {1'b0, 6'd32, 32'h11111111}});
    offer_item(OP_REQUEST, 32'h11111111, $urandom);
    drain_results();
  endtask

  task automatic test_lowered_limit();
    load_settings(16'd5, 16'd0, '0);
    repeat (3) offer_item(OP_REQUEST, 32'h44444444, $urandom);
    drain_results();
    load_settings(16'd1, 16'd0, '0);
    offer_item(OP_REQUEST, 32'h44444444, $urandom);
    drain_results();
  endtask

  task automatic test_window_overrun();
    repeat (3) offer_item(OP_TICK, $urandom, $urandom);
    drain_results();
    // tick count already past the new window length
    load_settings(16'd10, 16'd2, '0);
    offer_item(OP_TICK, $urandom, $urandom);
    drain_results();
  endtask

  task automatic run_traffic(input int n_items, input int pause_at);
    logic [RULES_N-1:0][RULE_W-1:0] rules;
    logic [LIMIT_W-1:0] limit;
    logic [TICK_W-1:0]  window;
    logic [ADDR_W-1:0]  hot_src, src;
    logic [5:0]         len;
    int k, pick;
    hot_src = src_pool[$urandom_range(POOL_N-1)];
    case ($urandom_range(9))
      0: limit = '1;
      1: limit = 16'd1;
      2: limit = 16'd2;
      default: limit = LIMIT_W'($urandom_range(12, 3));
    endcase
    case ($urandom_range(7))
      0: window = '0;
      1: window = '1;
      2: window = 16'd1;
      default: window = TICK_W'($urandom_range(6, 2));
    endcase
    for (k = 0; k < RULES_N; k++) begin
      case ($urandom_range(29))
        0: len = 6'd0;
        1, 2, 3: len = 6'($urandom_range(63, 33));
        default: len = 6'($urandom_range(32, 12));
      endcase
      rules[k] = {1'($urandom_range(1)), len,
                  ($urandom_range(1) ? src_pool[$urandom_range(POOL_N-1)] : 32'($urandom))};
    end
    load_settings(limit, window, rules);
    for (k = 0; k < n_items; k++) begin
      if (k == pause_at) drain_results();
      pick = $urandom_range(99);
      if (pick < 15) begin
        offer_item(OP_TICK, $urandom, $urandom);
      end else begin
        if (pick < 40) src = hot_src;
        else if (pick < 90) src = src_pool[$urandom_range(POOL_N-1)];
        else src = $urandom;
        offer_item(OP_REQUEST, src, $urandom);
      end
    end
    drain_results();
  endtask

  task automatic test_random_traffic();
    int m, p;
    for (m = 0; m < 3; m++) begin
      case (m)
        0: begin
          tx_idle_pct = 26;
          rx_idle_pct = 56;
        end
        1: begin
          tx_idle_pct = 56;
          rx_idle_pct = 26;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (p = 0; p < 3; p++)
        run_traffic(PHASE_ITEMS, (p == 1) ? PHASE_ITEMS / 2 : -1);
    end
  endtask

  // receiver stalls for a long stretch while the sender keeps offering
  task automatic test_output_stall();
    hold_output = 1'b1;
    run_traffic(40, -1);
  endtask

  initial begin
    int k;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_operation <= OP_REQUEST;
    in_src_ip    <= '0;
    in_dst_ip    <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_RATE_LIMIT;
    cfg_wdata    <= '0;
    rate_limit_q = 16'd10;
    window_len_q = '0;
    ticks_seen   = '0;
    drops_seen   = '0;
    for (k = 0; k < RULES_N; k++) block_rules[k] = '0;
    for (k = 0; k < TRACK_N; k++) begin
      track_addr[k]   = '0;
      track_count[k]  = '0;
      track_banned[k] = 1'b0;
      track_valid[k]  = 1'b0;
    end
    for (k = 0; k < POOL_N; k++) src_pool[k] = $urandom;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_range_and_ban();
    test_match_all_prefix();
    test_disabled_rule_zero_limit();
    test_lowered_limit();
    test_window_overrun();
    test_random_traffic();
    test_output_stall();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("[cidr_filter_rate_limiter_core] OK");
    else
      $display("[cidr_filter_rate_limiter_core] ERROR");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/cfr_pkg.sv
hw/rtl/cfr_ram.sv
hw/rtl/cfr_rule_match.sv
hw/rtl/cidr_filter_rate_limiter_core.sv
tb/sv/cidr_filter_rate_limiter_core_tb.sv
